[rtl/gfpmc_pkg.sv]
// Shared types, codes and fixed-point helpers for the gripper force PID controller.
// Used by the channel interfaces, the configuration register file and the top level.
package gfpmc_pkg;

  localparam int DATA_W        = 32;
  localparam int FRACTION_BITS = 16;
  localparam int TICK_RATE_HZ  = 50;
  localparam int CMD_W         = 2;
  localparam int MODE_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int ACT_W         = 3;

  typedef logic signed [DATA_W-1:0]   q_t;
  typedef logic signed [2*DATA_W-1:0] wide_t;

  // item commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WIDTH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODE  = 2'd2;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PIDX   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PIDY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESET  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_OFFSET = 3'd6;

  // work carried down the pipeline for one beat
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WAIT    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MANUAL  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PID     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESET   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SETREQ  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLRPREV = 3'd6;

  localparam q_t ONE_Q     = q_t'(1 << FRACTION_BITS);
  localparam q_t REQ_PIDX  = ONE_Q;
  localparam q_t REQ_RESET = q_t'(2 << FRACTION_BITS);
  localparam q_t REQ_PIDY  = q_t'(4 << FRACTION_BITS);

  // 0.002 and 0.08 rounded to nearest, 60.0 and 50.0
  localparam q_t WIDTH_OFFSET_RST = q_t'((2 * (1 << FRACTION_BITS) + 500) / 1000);
  localparam q_t CUR_WIDTH_RST    = q_t'((8 * (1 << FRACTION_BITS) + 50) / 100);
  localparam q_t REQ_WIDTH_RST    = q_t'(60 * (1 << FRACTION_BITS));
  localparam q_t RESET_WIDTH      = q_t'(50 * (1 << FRACTION_BITS));

  localparam q_t    Q_MAX      = q_t'(32'h7FFF_FFFF);
  localparam q_t    Q_MIN      = q_t'(32'h8000_0000);
  localparam wide_t SAT_HI     = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t SAT_LO     = 64'shFFFF_FFFF_8000_0000;
  localparam wide_t ROUND_HALF = wide_t'(64'sd1 <<< (FRACTION_BITS - 1));
  localparam wide_t SCALE_K    = wide_t'(1000);
  localparam wide_t TICK_K     = wide_t'(TICK_RATE_HZ);

  // floor(x / TICK_RATE_HZ) by reciprocal: exact for any 32-bit magnitude
  localparam int DIV_SHIFT  = DATA_W + $clog2(TICK_RATE_HZ);
  localparam int DIV_PROD_W = DIV_SHIFT + DATA_W;
  localparam logic [DATA_W:0] DIV_MAGIC =
    (DATA_W + 1)'(((96'd1 << DIV_SHIFT) + 96'(TICK_RATE_HZ - 1)) / 96'(TICK_RATE_HZ));

  typedef struct packed {
    q_t gain_p;
    q_t gain_i;
    q_t gain_d;
    q_t force_setpoint;
    q_t width_max;
    q_t width_min;
    q_t width_offset;
  } cfg_t;

  function automatic wide_t sext(input q_t x);
    return {{DATA_W{x[DATA_W-1]}}, x};
  endfunction

  function automatic q_t sat_q(input wide_t x);
    if (x > SAT_HI) return Q_MAX;
    if (x < SAT_LO) return Q_MIN;
    return x[DATA_W-1:0];
  endfunction

  function automatic q_t times_k(input q_t x);
    return sat_q(sext(x) * SCALE_K);
  endfunction

  function automatic wide_t mul_full(input q_t a, input q_t b);
    return a * b;
  endfunction

  function automatic q_t floor_div_tick(input q_t x);
    logic [DATA_W-1:0]     mag;
    logic [DIV_PROD_W-1:0] prod;
    logic [DATA_W-1:0]     quo;
    // negative: floor(x/d) = -ceil(|x|/d) = -floor((|x| + d - 1)/d)
    if (x[DATA_W-1]) mag = ~x + DATA_W'(TICK_RATE_HZ);
    else mag = x;
    prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_MAGIC);
    quo  = prod[DIV_SHIFT +: DATA_W];
    if (x[DATA_W-1]) return q_t'(~quo + 1'b1);
    return q_t'(quo);
  endfunction

endpackage

[rtl/gfpmc_channels.sv]
// Valid/ready channel interfaces: input items, result items and configuration writes.
// Depends on gfpmc_pkg for field widths.
interface gfpmc_item_if;
  import gfpmc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  q_t               force_x;
  q_t               force_y;
  q_t               finger_position;
  q_t               request_value;

  modport source (output valid, command, force_x, force_y, finger_position, request_value,
                  input ready);
  modport sink (input valid, command, force_x, force_y, finger_position, request_value,
                output ready);
endinterface

interface gfpmc_result_if;
  import gfpmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  q_t                measured_value;
  q_t                output_unclamped;
  q_t                output_clamped;
  q_t                last_error;
  q_t                position_report;
  logic              send_goal;

  modport source (output valid, mode, measured_value, output_unclamped, output_clamped,
                  last_error, position_report, send_goal, input ready);
  modport sink (input valid, mode, measured_value, output_unclamped, output_clamped,
                last_error, position_report, send_goal, output ready);
endinterface

interface gfpmc_cfg_if;
  import gfpmc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  q_t                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/gfpmc_cfg_regs.sv]
// Configuration register file: gains, setpoint, clamp bounds and width offset.
// Depends on gfpmc_pkg and the gfpmc_cfg_if channel.
module gfpmc_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  gfpmc_cfg_if.sink         cfg,
  output gfpmc_pkg::cfg_t   regs
);
  import gfpmc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_p         <= '0;
      regs.gain_i         <= '0;
      regs.gain_d         <= '0;
      regs.force_setpoint <= '0;
      regs.width_max      <= '0;
      regs.width_min      <= '0;
      regs.width_offset   <= WIDTH_OFFSET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_GAIN_P:       regs.gain_p         <= cfg.data;
        CFG_GAIN_I:       regs.gain_i         <= cfg.data;
        CFG_GAIN_D:       regs.gain_d         <= cfg.data;
        CFG_SETPOINT:     regs.force_setpoint <= cfg.data;
        CFG_WIDTH_MAX:    regs.width_max      <= cfg.data;
        CFG_WIDTH_MIN:    regs.width_min      <= cfg.data;
        CFG_WIDTH_OFFSET: regs.width_offset   <= cfg.data;
        default: ;  // beats past the register list are dropped
      endcase
    end
  end

endmodule

[rtl/gripper_force_pid_mode_controller_unit.sv]
// Gripper force PID controller: mode sequencing, PID with saturated integral, output clamp.
// Depends on gfpmc_pkg, the channel interfaces and gfpmc_cfg_regs.
//
// Channels: item (sink) carries ticks, width requests and mode requests; result (source)
// carries one beat per tick and none for requests; cfg (sink) writes the seven registers,
// is always ready and should only be written while no item is in flight.
// Throughput: one item per cycle while result.ready does not stall the pipeline. A tick's
// result passes through the five register ranks of the pipeline in order (mode decode and
// error, integral and derivative, the three gain multipliers, sum and clamp, x1000 scaling
// with the width state and the result register).
// The mode register is updated in the first rank, integral and previous error in the
// second, and width request, current width and held outputs in the last rank, so every
// state update sees the items ahead of it in order.
// Each rank holds while the rank after it is full and stalled; a stalled result leaves the
// earlier ranks free to take new items until the pipeline fills, then item.ready drops.
// Reset (synchronous, active high) empties the pipeline, enters wait mode, clears the
// integral, previous error and held outputs, sets width 0.08, request 60.0 and the
// register defaults.
module gripper_force_pid_mode_controller_unit (
  input  logic            clk,
  input  logic            rst,
  gfpmc_item_if.sink      item,
  gfpmc_result_if.source  result,
  gfpmc_cfg_if.sink       cfg
);
  import gfpmc_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic              tick;
    logic [MODE_W-1:0] mode;
    q_t                measured;
    q_t                err;
    q_t                pos;
    q_t                req;
  } s1_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic              tick;
    logic [MODE_W-1:0] mode;
    q_t                measured;
    q_t                err;
    q_t                integ;
    q_t                deriv;
    q_t                prev;
    q_t                pos;
    q_t                req;
  } s2_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic              tick;
    logic [MODE_W-1:0] mode;
    q_t                measured;
    q_t                prev;
    q_t                pos;
    q_t                req;
    wide_t             prod_p;
    wide_t             prod_i;
    wide_t             prod_d;
  } s3_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic              tick;
    logic [MODE_W-1:0] mode;
    q_t                measured;
    q_t                prev;
    q_t                pos_k;
    q_t                req;
    q_t                width;
    q_t                clamped;
  } s4_t;

  cfg_t regs;

  gfpmc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // pipeline control
  logic s1_valid, s2_valid, s3_valid, s4_valid, res_valid;
  logic adv1, adv2, adv3, adv4, adv5;
  logic ld2, ld3, ld4, ld5;
  logic accept;

  assign adv5   = !res_valid || result.ready;
  assign ld5    = s4_valid && adv5;
  assign adv4   = !s4_valid || adv5;
  assign ld4    = s3_valid && adv4;
  assign adv3   = !s3_valid || adv4;
  assign ld3    = s2_valid && adv3;
  assign adv2   = !s2_valid || adv3;
  assign ld2    = s1_valid && adv2;
  assign adv1   = !s1_valid || adv2;
  assign accept = item.valid && adv1;
  assign item.ready = adv1;

  // ---------------------------------------------------------------- rank 1: decode
  logic [MODE_W-1:0] mode_reg, mode_next;
  logic              keep;
  s1_t               s1, s1_next;
  q_t                force_y_neg;

  assign force_y_neg = (item.force_y == Q_MIN) ? Q_MAX : q_t'(-item.force_y);

  always_comb begin
    mode_next     = mode_reg;
    keep          = 1'b0;
    s1_next.act   = ACT_NONE;
    s1_next.tick  = 1'b0;
    unique case (item.command)
      CMD_TICK: begin
        keep         = 1'b1;
        s1_next.tick = 1'b1;
        unique case (mode_reg) inside
          MODE_WAIT: begin
            s1_next.act = ACT_WAIT;
            mode_next   = MODE_MANUAL;
          end
          MODE_MANUAL: s1_next.act = ACT_MANUAL;
          MODE_PIDX, MODE_PIDY: s1_next.act = ACT_PID;
          MODE_RESET: begin
            s1_next.act = ACT_RESET;
            mode_next   = MODE_MANUAL;
          end
          default: s1_next.act = ACT_NONE;
        endcase
      end
      CMD_WIDTH: begin
        keep        = 1'b1;
        s1_next.act = ACT_SETREQ;
      end
      CMD_MODE: begin
        if (item.request_value == REQ_PIDX) begin
          keep        = 1'b1;
          s1_next.act = ACT_CLRPREV;
          mode_next   = MODE_PIDX;
        end else if (item.request_value == REQ_RESET) begin
          mode_next = MODE_RESET;
        end else if (item.request_value == REQ_PIDY) begin
          mode_next = MODE_PIDY;
        end
      end
      default: ;  // unused command: drop
    endcase
    s1_next.mode     = mode_next;
    s1_next.measured = (mode_reg == MODE_PIDY) ? force_y_neg : item.force_x;
    s1_next.err      = sat_q(sext(regs.force_setpoint) - sext(s1_next.measured));
    s1_next.pos      = item.finger_position;
    s1_next.req      = item.request_value;
  end

  // ---------------------------------------------------------------- rank 2: integral
  q_t  integral_acc, previous_error;
  q_t  integ_after, prev_after;
  q_t  err_dt;
  s2_t s2;

  assign err_dt = floor_div_tick(s1.err);

  always_comb begin
    integ_after = integral_acc;
    prev_after  = previous_error;
    case (s1.act) inside
      ACT_WAIT, ACT_RESET: begin
        integ_after = '0;
        prev_after  = '0;
      end
      ACT_CLRPREV: prev_after = '0;
      ACT_PID: begin
        integ_after = sat_q(sext(integral_acc) + sext(err_dt));
        prev_after  = s1.err;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- rank 4: sum and clamp
  s3_t   s3;
  s4_t   s4;
  wide_t sum_all;
  q_t    width_now, clamped_now;

  assign sum_all = ((s3.prod_p + ROUND_HALF) >>> FRACTION_BITS)
                 + ((s3.prod_i + ROUND_HALF) >>> FRACTION_BITS)
                 + ((s3.prod_d + ROUND_HALF) >>> FRACTION_BITS);
  assign width_now = sat_q(sext(regs.width_offset) - sum_all);

  always_comb begin
    // when the bounds cross, the upper bound is checked first: values above it take it, the rest take the lower bound
    if (width_now > regs.width_max) clamped_now = regs.width_max;
    else if (width_now < regs.width_min) clamped_now = regs.width_min;
    else clamped_now = width_now;
  end

  // ---------------------------------------------------------------- rank 5: width state
  q_t requested_width, current_width;
  q_t held_unclamped, held_clamped, held_measured;
  q_t req_next, cur_next, hu_next, hc_next, hm_next;
  q_t scale_u_src, scale_c_src, scaled_u, scaled_c;
  logic goal;

  assign scale_u_src = (s4.act == ACT_PID) ? s4.width   : requested_width;
  assign scale_c_src = (s4.act == ACT_PID) ? s4.clamped : requested_width;
  assign scaled_u    = times_k(scale_u_src);
  assign scaled_c    = times_k(scale_c_src);

  always_comb begin
    req_next = requested_width;
    cur_next = current_width;
    hu_next  = held_unclamped;
    hc_next  = held_clamped;
    hm_next  = held_measured;
    goal     = 1'b0;
    case (s4.act)
      ACT_SETREQ: req_next = s4.req;
      ACT_RESET:  req_next = RESET_WIDTH;
      ACT_MANUAL: begin
        if (requested_width != current_width) begin
          cur_next = requested_width;
          hu_next  = scaled_u;
          hc_next  = scaled_u;
          goal     = 1'b1;
        end
      end
      ACT_PID: begin
        hm_next  = s4.measured;
        hu_next  = scaled_u;
        hc_next  = scaled_c;
        cur_next = s4.clamped;
        goal     = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      s4_valid        <= 1'b0;
      res_valid       <= 1'b0;
      mode_reg        <= MODE_WAIT;
      integral_acc    <= '0;
      previous_error  <= '0;
      requested_width <= REQ_WIDTH_RST;
      current_width   <= CUR_WIDTH_RST;
      held_unclamped  <= '0;
      held_clamped    <= '0;
      held_measured   <= '0;
    end else begin
      if (adv1) s1_valid  <= accept && keep;
      if (adv2) s2_valid  <= s1_valid;
      if (adv3) s3_valid  <= s2_valid;
      if (adv4) s4_valid  <= s3_valid;
      if (adv5) res_valid <= s4_valid && s4.tick;
      if (accept) mode_reg <= mode_next;
      if (ld2) begin
        integral_acc   <= integ_after;
        previous_error <= prev_after;
      end
      if (ld5) begin
        requested_width <= req_next;
        current_width   <= cur_next;
        held_unclamped  <= hu_next;
        held_clamped    <= hc_next;
        held_measured   <= hm_next;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  logic [MODE_W-1:0] res_mode;
  q_t                res_measured, res_unclamped, res_clamped, res_error, res_position;
  logic              res_goal;

  always_ff @(posedge clk) begin
    if (accept) s1 <= s1_next;
    if (ld2) begin
      s2.act      <= s1.act;
      s2.tick     <= s1.tick;
      s2.mode     <= s1.mode;
      s2.measured <= s1.measured;
      s2.err      <= s1.err;
      s2.integ    <= integ_after;
      s2.deriv    <= sat_q((sext(s1.err) - sext(previous_error)) * TICK_K);
      s2.prev     <= prev_after;
      s2.pos      <= s1.pos;
      s2.req      <= s1.req;
    end
    if (ld3) begin
      s3.act      <= s2.act;
      s3.tick     <= s2.tick;
      s3.mode     <= s2.mode;
      s3.measured <= s2.measured;
      s3.prev     <= s2.prev;
      s3.pos      <= s2.pos;
      s3.req      <= s2.req;
      s3.prod_p   <= mul_full(regs.gain_p, s2.err);
      s3.prod_i   <= mul_full(regs.gain_i, s2.integ);
      s3.prod_d   <= mul_full(regs.gain_d, s2.deriv);
    end
    if (ld4) begin
      s4.act      <= s3.act;
      s4.tick     <= s3.tick;
      s4.mode     <= s3.mode;
      s4.measured <= s3.measured;
      s4.prev     <= s3.prev;
      s4.pos_k    <= times_k(s3.pos);
      s4.req      <= s3.req;
      s4.width    <= width_now;
      s4.clamped  <= clamped_now;
    end
    if (ld5) begin
      res_mode      <= s4.mode;
      res_measured  <= hm_next;
      res_unclamped <= hu_next;
      res_clamped   <= hc_next;
      res_error     <= s4.prev;
      res_position  <= s4.pos_k;
      res_goal      <= goal;
    end
  end

  assign result.valid            = res_valid;
  assign result.mode             = res_mode;
  assign result.measured_value   = res_measured;
  assign result.output_unclamped = res_unclamped;
  assign result.output_clamped   = res_clamped;
  assign result.last_error       = res_error;
  assign result.position_report  = res_position;
  assign result.send_goal        = res_goal;

`ifndef SYNTHESIS
  a_no_wait_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_mode != MODE_WAIT)
    else $error("result reports wait mode");

  a_goal_mode: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_goal) |->
      (res_mode == MODE_MANUAL || res_mode == MODE_PIDX || res_mode == MODE_PIDY))
    else $error("goal issued outside manual or PID mode");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (ld2 && (s1.act == ACT_WAIT || s1.act == ACT_RESET)) |=>
      (integral_acc == '0 && previous_error == '0))
    else $error("integral or previous error not cleared");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ld5))
    else $error("result raised without a beat from the last rank");
`endif

endmodule
